@@ hw/rtl/line_sensor_pattern_classifier_defines.svh @@
// Assertion macros shared by the line sensor classifier RTL.
`ifndef LINE_SENSOR_PATTERN_CLASSIFIER_DEFINES_SVH
`define LINE_SENSOR_PATTERN_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lspc check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lspc check failed");

`endif

@@ hw/rtl/lspc_pkg.sv @@
// Types and constants of the line sensor pattern classifier.
package lspc_pkg;

	localparam int unsigned SENS_W    = 10;
	localparam int unsigned COUNT_W   = 3;
	localparam int unsigned NUM_SENS  = 5;
	localparam int unsigned NUM_REGS  = 8;
	localparam int unsigned ADDR_W    = 5;
	localparam int unsigned DATA_W    = 32;

	localparam logic [SENS_W-1:0]  READ_MAX        = SENS_W'(1000);
	localparam logic [COUNT_W-1:0] CROSS_MIN_COUNT = COUNT_W'(4);

	localparam logic [SENS_W-1:0] RST_BLACK_THR   = SENS_W'(700);
	localparam logic [SENS_W-1:0] RST_GREY_LOW    = SENS_W'(200);
	localparam logic [SENS_W-1:0] RST_GREY_HIGH   = SENS_W'(600);
	localparam logic [SENS_W-1:0] RST_GREY_LEVEL  = SENS_W'(0);
	localparam logic [SENS_W-1:0] RST_GREEN_LOW   = SENS_W'(300);
	localparam logic [SENS_W-1:0] RST_GREEN_HIGH  = SENS_W'(700);
	localparam logic [SENS_W-1:0] RST_ABOVE_WHITE = SENS_W'(100);
	localparam logic [SENS_W-1:0] RST_SIDE_MARGIN = SENS_W'(100);

	typedef enum logic [2:0] {
		REG_BLACK_THR   = 3'd0,
		REG_GREY_LOW    = 3'd1,
		REG_GREY_HIGH   = 3'd2,
		REG_GREY_LEVEL  = 3'd3,
		REG_GREEN_LOW   = 3'd4,
		REG_GREEN_HIGH  = 3'd5,
		REG_ABOVE_WHITE = 3'd6,
		REG_SIDE_MARGIN = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [SENS_W-1:0] sensor_0;
		logic [SENS_W-1:0] sensor_1;
		logic [SENS_W-1:0] sensor_2;
		logic [SENS_W-1:0] sensor_3;
		logic [SENS_W-1:0] sensor_4;
	} sample_t;

	typedef struct packed {
		logic [COUNT_W-1:0] black_count;
		logic               line_visible;
		logic               crossing;
		logic               split;
		logic               green_line;
		logic               grey_left;
		logic               grey_right;
		logic               grey_both;
	} result_t;

	function automatic logic [SENS_W-1:0] clamp_read(input logic [SENS_W-1:0] v);
		return (v > READ_MAX) ? READ_MAX : v;
	endfunction

endpackage

@@ hw/rtl/line_sensor_pattern_classifier.sv @@
// Line sensor pattern classifier top level with APB register file.
// The input stage feeds the result stage; the compare logic sits between the two.
// Throughput: one sample per cycle while no held result stalls the input stage.
// A held result stalls the input stage only when that stage is also full.
// Reset (arst_n low, asynchronous) empties both stages and restores register defaults.
`include "line_sensor_pattern_classifier_defines.svh"

module line_sensor_pattern_classifier
	import lspc_pkg::*;
#(
	parameter int unsigned GREY_MARGIN     = 100,
	parameter int unsigned SPLIT_MIN_COUNT = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  sample_t           sample,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int unsigned GW = $clog2(1024 + GREY_MARGIN) + 1;
	localparam logic signed [GW-1:0] MARGIN = GW'(GREY_MARGIN);
	localparam logic [COUNT_W-1:0] SPLIT_MIN = COUNT_W'(SPLIT_MIN_COUNT);

	logic [SENS_W-1:0] black_thr_q, grey_low_q, grey_high_q, grey_level_q;
	logic [SENS_W-1:0] green_low_q, green_high_q, above_white_q, side_margin_q;

	logic              valid_s1;
	logic [SENS_W-1:0] sens_s1 [NUM_SENS];
	logic              advance;
	logic              take_s1;
	logic              cfg_write;
	cfg_reg_t          cfg_sel;

	logic [NUM_SENS-1:0]    black;
	logic [COUNT_W-1:0]     count;
	logic [SENS_W-1:0]      min01, min23, min03, white;
	logic [SENS_W-1:0]      max01, max23, max03, peak;
	logic signed [GW-1:0]   band_lo, band_hi;
	logic                   left, right;
	result_t                res_d;

	function automatic logic in_grey(
		input logic [SENS_W-1:0] v,
		input logic signed [GW-1:0] lo,
		input logic signed [GW-1:0] hi,
		input logic [SENS_W-1:0] thr
	);
		logic signed [GW-1:0] vs;
		vs = $signed(GW'(v));
		return (vs > lo) && (vs < hi) && (v < thr);
	endfunction

	function automatic logic grey_side(
		input logic [SENS_W-1:0] outer,
		input logic [SENS_W-1:0] inner,
		input logic [SENS_W-1:0] other,
		input logic [SENS_W-1:0] wht,
		input logic grey_ok,
		input logic [SENS_W-1:0] above,
		input logic [SENS_W-1:0] glow,
		input logic [SENS_W-1:0] margin
	);
		return grey_ok
			&& ((outer - wht) > above)
			&& (inner < glow)
			&& ({1'b0, other} <= ({1'b0, outer} + {1'b0, margin}));
	endfunction

	// Register file
	assign pready    = 1'b1;
	assign cfg_sel   = cfg_reg_t'(paddr[ADDR_W-1:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			black_thr_q   <= RST_BLACK_THR;
			grey_low_q    <= RST_GREY_LOW;
			grey_high_q   <= RST_GREY_HIGH;
			grey_level_q  <= RST_GREY_LEVEL;
			green_low_q   <= RST_GREEN_LOW;
			green_high_q  <= RST_GREEN_HIGH;
			above_white_q <= RST_ABOVE_WHITE;
			side_margin_q <= RST_SIDE_MARGIN;
		end else if (cfg_write) begin
			case (cfg_sel)
				REG_BLACK_THR:   black_thr_q   <= pwdata[SENS_W-1:0];
				REG_GREY_LOW:    grey_low_q    <= pwdata[SENS_W-1:0];
				REG_GREY_HIGH:   grey_high_q   <= pwdata[SENS_W-1:0];
				REG_GREY_LEVEL:  grey_level_q  <= pwdata[SENS_W-1:0];
				REG_GREEN_LOW:   green_low_q   <= pwdata[SENS_W-1:0];
				REG_GREEN_HIGH:  green_high_q  <= pwdata[SENS_W-1:0];
				REG_ABOVE_WHITE: above_white_q <= pwdata[SENS_W-1:0];
				REG_SIDE_MARGIN: side_margin_q <= pwdata[SENS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			REG_BLACK_THR:   prdata = DATA_W'(black_thr_q);
			REG_GREY_LOW:    prdata = DATA_W'(grey_low_q);
			REG_GREY_HIGH:   prdata = DATA_W'(grey_high_q);
			REG_GREY_LEVEL:  prdata = DATA_W'(grey_level_q);
			REG_GREEN_LOW:   prdata = DATA_W'(green_low_q);
			REG_GREEN_HIGH:  prdata = DATA_W'(green_high_q);
			REG_ABOVE_WHITE: prdata = DATA_W'(above_white_q);
			REG_SIDE_MARGIN: prdata = DATA_W'(side_margin_q);
			default:         prdata = '0;
		endcase
	end

	// Pipeline control: advance the result stage when it is empty or taken
	assign advance      = !result_valid || !result_stall;
	assign sample_stall = valid_s1 && !advance;
	assign take_s1      = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (advance) begin
				result_valid <= valid_s1;
			end
			if (!sample_stall) begin
				valid_s1 <= sample_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			sens_s1[0] <= clamp_read(sample.sensor_0);
			sens_s1[1] <= clamp_read(sample.sensor_1);
			sens_s1[2] <= clamp_read(sample.sensor_2);
			sens_s1[3] <= clamp_read(sample.sensor_3);
			sens_s1[4] <= clamp_read(sample.sensor_4);
		end
		if (advance && valid_s1) begin
			result <= res_d;
		end
	end

	// Classification
	always_comb begin
		for (int i = 0; i < NUM_SENS; i++) begin
			black[i] = sens_s1[i] > black_thr_q;
		end
		count = COUNT_W'($countones(black));

		min01 = (sens_s1[1] < sens_s1[0]) ? sens_s1[1] : sens_s1[0];
		min23 = (sens_s1[3] < sens_s1[2]) ? sens_s1[3] : sens_s1[2];
		min03 = (min23 < min01) ? min23 : min01;
		white = (sens_s1[4] < min03) ? sens_s1[4] : min03;
		max01 = (sens_s1[1] > sens_s1[0]) ? sens_s1[1] : sens_s1[0];
		max23 = (sens_s1[3] > sens_s1[2]) ? sens_s1[3] : sens_s1[2];
		max03 = (max23 > max01) ? max23 : max01;
		peak  = (sens_s1[4] > max03) ? sens_s1[4] : max03;

		if (grey_level_q != '0) begin
			band_lo = $signed(GW'(grey_level_q)) - MARGIN;
			band_hi = $signed(GW'(grey_level_q)) + MARGIN;
		end else begin
			band_lo = $signed(GW'(grey_low_q));
			band_hi = $signed(GW'(grey_high_q));
		end

		left = grey_side(sens_s1[0], sens_s1[1], sens_s1[4], white,
			in_grey(sens_s1[0], band_lo, band_hi, black_thr_q),
			above_white_q, grey_low_q, side_margin_q);
		right = grey_side(sens_s1[4], sens_s1[3], sens_s1[0], white,
			in_grey(sens_s1[4], band_lo, band_hi, black_thr_q),
			above_white_q, grey_low_q, side_margin_q);

		res_d.black_count  = count;
		res_d.line_visible = count != '0;
		res_d.crossing     = (count >= CROSS_MIN_COUNT) && black[2];
		res_d.split        = (count >= SPLIT_MIN) && (black[0] || black[4]);
		res_d.green_line   = (peak >= green_low_q) && (peak <= green_high_q);
		res_d.grey_left    = left;
		res_d.grey_right   = right;
		res_d.grey_both    = left && right;
	end

	`LSPC_ASSERT_NEXT(a_stage_moves, clk, arst_n, valid_s1 && advance, result_valid)
	`LSPC_ASSERT_NOW(a_stall_only_full, clk, arst_n, sample_stall,
		valid_s1 && result_valid && result_stall)
	`LSPC_ASSERT_NOW(a_both_sides, clk, arst_n, result_valid && result.grey_both,
		result.grey_left && result.grey_right)
	`LSPC_ASSERT_NOW(a_visible_count, clk, arst_n, result_valid,
		result.line_visible == (result.black_count != '0))

endmodule

@@ sim/line_sensor_pattern_classifier_tb.sv @@
// Self-checking testbench of the line sensor pattern classifier: random and directed readings.
module line_sensor_pattern_classifier_tb;
	import lspc_pkg::*;

	localparam int GREY_MARGIN     = 100;
	localparam int SPLIT_MIN_COUNT = 3;
	localparam int PIPE_LATENCY    = 2;
	localparam int LONG_HOLD       = 300;
	localparam int WATCHDOG_LIMIT  = 3000;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              sample_valid = 1'b0;
	logic              sample_stall;
	sample_t           sample       = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	result_t           result;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [ADDR_W-1:0] paddr        = '0;
	logic [DATA_W-1:0] pwdata       = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int cfg_regs [NUM_REGS] = '{RST_BLACK_THR, RST_GREY_LOW, RST_GREY_HIGH, RST_GREY_LEVEL,
		RST_GREEN_LOW, RST_GREEN_HIGH, RST_ABOVE_WHITE, RST_SIDE_MARGIN};

	result_t pending_classes [$];
	result_t want;
	int      bad_fields  = 0;
	bit      tx_idle_on  = 1'b1;
	bit      rx_idle_on  = 1'b1;
	int      hold_req    = 0;
	int      hold_seen   = 0;
	int      hold_left   = 0;
	int      run_left    = 0;
	int      quiet_count = 0;

	line_sensor_pattern_classifier #(
		.GREY_MARGIN    (GREY_MARGIN),
		.SPLIT_MIN_COUNT(SPLIT_MIN_COUNT)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #5 clk = ~clk;

	function automatic int clamped(logic [SENS_W-1:0] v);
		return (v > READ_MAX) ? int'(READ_MAX) : int'(v);
	endfunction

	function automatic logic [SENS_W-1:0] clip(int v);
		if (v < 0)
			return '0;
		if (v > 1023)
			return '1;
		return v[SENS_W-1:0];
	endfunction

	function automatic sample_t make_sample(int a, int b, int c, int d, int e);
		sample_t s;
		s.sensor_0 = clip(a);
		s.sensor_1 = clip(b);
		s.sensor_2 = clip(c);
		s.sensor_3 = clip(d);
		s.sensor_4 = clip(e);
		return s;
	endfunction

	function automatic bit grey_edge(int outer, int inner, int other, int white);
		int lo;
		int hi;
		lo = (cfg_regs[REG_GREY_LEVEL] != 0) ? cfg_regs[REG_GREY_LEVEL] - GREY_MARGIN
			: cfg_regs[REG_GREY_LOW];
		hi = (cfg_regs[REG_GREY_LEVEL] != 0) ? cfg_regs[REG_GREY_LEVEL] + GREY_MARGIN
			: cfg_regs[REG_GREY_HIGH];
		return outer > lo && outer < hi && outer < cfg_regs[REG_BLACK_THR]
			&& outer - white > cfg_regs[REG_ABOVE_WHITE]
			&& inner < cfg_regs[REG_GREY_LOW]
			&& other - outer <= cfg_regs[REG_SIDE_MARGIN];
	endfunction

	function automatic result_t classify_reading(sample_t smp);
		int      rd [NUM_SENS];
		int      thr;
		int      white;
		int      peak;
		int      cnt;
		bit      left;
		bit      right;
		result_t r;
		rd[0] = clamped(smp.sensor_0);
		rd[1] = clamped(smp.sensor_1);
		rd[2] = clamped(smp.sensor_2);
		rd[3] = clamped(smp.sensor_3);
		rd[4] = clamped(smp.sensor_4);
		thr   = cfg_regs[REG_BLACK_THR];
		white = rd[0];
		peak  = rd[0];
		cnt   = 0;
		foreach (rd[i]) begin
			if (rd[i] > thr)
				cnt++;
			if (rd[i] < white)
				white = rd[i];
			if (rd[i] > peak)
				peak = rd[i];
		end
		left  = grey_edge(rd[0], rd[1], rd[4], white);
		right = grey_edge(rd[4], rd[3], rd[0], white);
		r.black_count  = cnt[COUNT_W-1:0];
		r.line_visible = cnt >= 1;
		r.crossing     = cnt >= int'(CROSS_MIN_COUNT) && rd[2] > thr;
		r.split        = cnt >= SPLIT_MIN_COUNT && (rd[0] > thr || rd[4] > thr);
		r.green_line   = peak >= cfg_regs[REG_GREEN_LOW] && peak <= cfg_regs[REG_GREEN_HIGH];
		r.grey_left    = left;
		r.grey_right   = right;
		r.grey_both    = left && right;
		return r;
	endfunction

	function automatic int near_point();
		int base;
		int lvl;
		lvl = cfg_regs[REG_GREY_LEVEL];
		case ($urandom_range(0, 9))
			0: base = 0;
			1: base = READ_MAX;
			2: base = $urandom_range(int'(READ_MAX) + 1, 1023);
			3: base = cfg_regs[REG_BLACK_THR];
			4: base = cfg_regs[REG_GREY_LOW];
			5: base = cfg_regs[REG_GREY_HIGH];
			6: base = (lvl != 0) ? lvl - GREY_MARGIN
				: cfg_regs[REG_GREY_LOW] + cfg_regs[REG_ABOVE_WHITE];
			7: base = (lvl != 0) ? lvl + GREY_MARGIN : int'($urandom_range(0, 1023));
			8: base = cfg_regs[REG_GREEN_LOW];
			default: base = cfg_regs[REG_GREEN_HIGH];
		endcase
		return base + int'($urandom_range(0, 4)) - 2;
	endfunction

	function automatic sample_t shaped_sample();
		int kind;
		int ctr;
		int tmp;
		int rd [NUM_SENS];
		kind = $urandom_range(0, 99);
		if (kind < 25) begin
			foreach (rd[i])
				rd[i] = $urandom_range(0, 1023);
		end else if (kind < 60) begin
			foreach (rd[i])
				rd[i] = near_point();
		end else begin
			ctr = (cfg_regs[REG_GREY_LEVEL] != 0) ? cfg_regs[REG_GREY_LEVEL]
				: (cfg_regs[REG_GREY_LOW] + cfg_regs[REG_GREY_HIGH]) / 2;
			rd[0] = ctr + int'($urandom_range(0, 120)) - 60;
			rd[4] = ($urandom_range(0, 1) != 0) ? ctr + int'($urandom_range(0, 120)) - 60
				: near_point();
			rd[1] = $urandom_range(0, cfg_regs[REG_GREY_LOW]);
			rd[3] = $urandom_range(0, cfg_regs[REG_GREY_LOW]);
			rd[2] = $urandom_range(0, cfg_regs[REG_GREY_LOW] + 20);
			if ($urandom_range(0, 3) == 0)
				rd[$urandom_range(0, 1) * 2 + 1] = near_point();
			if ($urandom_range(0, 1) != 0) begin
				tmp   = rd[0];
				rd[0] = rd[4];
				rd[4] = tmp;
			end
		end
		return make_sample(rd[0], rd[1], rd[2], rd[3], rd[4]);
	endfunction

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	task automatic report_field(string name, int expected_val, int actual_val);
		if (expected_val != actual_val) begin
			$display("%0t ERROR %s expected %0d actual %0d", $time, name, expected_val,
				actual_val);
			bad_fields++;
		end
	endtask

	task automatic send_sample(sample_t smp);
		int gap;
		gap = tx_idle_on ? idle_gap() : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= smp;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		pending_classes.push_back(classify_reading(smp));
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		while (pending_classes.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int val);
		logic [DATA_W-1:0] word;
		word                 = $urandom;
		word[SENS_W-1:0]     = val[SENS_W-1:0];
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(int'(idx) * 4);
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		cfg_regs[idx] = val[SENS_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		report_field("readback", cfg_regs[idx], prdata[SENS_W-1:0]);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_regs(int bthr, int glo, int ghi, int glvl, int gnlo, int gnhi,
		int abw, int smg);
		wait_drained();
		write_reg(REG_BLACK_THR, bthr);
		write_reg(REG_GREY_LOW, glo);
		write_reg(REG_GREY_HIGH, ghi);
		write_reg(REG_GREY_LEVEL, glvl);
		write_reg(REG_GREEN_LOW, gnlo);
		write_reg(REG_GREEN_HIGH, gnhi);
		write_reg(REG_ABOVE_WHITE, abw);
		write_reg(REG_SIDE_MARGIN, smg);
	endtask

	task automatic test_random_mix(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) begin
				tx_idle_on = $urandom_range(0, 3) != 0;
				rx_idle_on <= $urandom_range(0, 3) != 0;
			end
			send_sample(shaped_sample());
		end
		tx_idle_on = 1'b1;
		rx_idle_on <= 1'b1;
	endtask

	task automatic test_directed_defaults();
		send_sample(make_sample(0, 0, 0, 0, 0));
		send_sample(make_sample(1000, 1000, 1000, 1000, 1000));
		send_sample(make_sample(1023, 1023, 1023, 1023, 1023));
		send_sample(make_sample(700, 700, 700, 700, 700));
		send_sample(make_sample(701, 701, 701, 701, 701));
		send_sample(make_sample(701, 701, 701, 701, 0));
		send_sample(make_sample(701, 701, 0, 701, 701));
		send_sample(make_sample(0, 701, 701, 701, 0));
		send_sample(make_sample(701, 0, 0, 0, 701));
		send_sample(make_sample(1010, 1001, 0, 0, 0));
		send_sample(make_sample(299, 0, 0, 0, 0));
		send_sample(make_sample(300, 0, 0, 0, 0));
		send_sample(make_sample(0, 0, 0, 0, 700));
		send_sample(make_sample(0, 0, 0, 0, 701));
		send_sample(make_sample(400, 100, 100, 100, 450));
		send_sample(make_sample(450, 100, 100, 100, 400));
		send_sample(make_sample(400, 50, 50, 50, 400));
		send_sample(make_sample(400, 100, 100, 100, 501));
		send_sample(make_sample(400, 200, 100, 100, 400));
		send_sample(make_sample(200, 0, 0, 0, 600));
		send_sample(make_sample(201, 0, 0, 0, 599));
		send_sample(make_sample(250, 150, 180, 150, 250));
		send_sample(make_sample(699, 0, 0, 0, 699));
	endtask

	task automatic test_random_defaults();
		test_random_mix(120);
	endtask

	task automatic test_reg_extremes();
		program_regs(0, 0, 0, 0, 0, 0, 0, 0);
		test_random_mix(40);
		program_regs(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023);
		test_random_mix(40);
	endtask

	task automatic test_calibrated_grey();
		program_regs(700, 200, 600, 1, 300, 700, 0, 100);
		test_random_mix(35);
		program_regs(650, 150, 900, 450, 0, 1023, 50, 0);
		test_random_mix(35);
		program_regs(1023, 1023, 0, 1023, 1000, 1000, 0, 1023);
		test_random_mix(35);
	endtask

	task automatic test_random_settings();
		int glo;
		int gnlo;
		for (int k = 0; k < 4; k++) begin
			glo  = $urandom_range(0, 500);
			gnlo = $urandom_range(0, 1000);
			program_regs($urandom_range(300, 1023), glo, $urandom_range(glo, 1023),
				($urandom_range(0, 1) != 0) ? int'($urandom_range(1, 1023)) : 0,
				gnlo, $urandom_range(gnlo, 1023), $urandom_range(0, 300),
				$urandom_range(0, 300));
			test_random_mix(35);
		end
	endtask

	task automatic test_backpressure();
		program_regs(RST_BLACK_THR, RST_GREY_LOW, RST_GREY_HIGH, RST_GREY_LEVEL,
			RST_GREEN_LOW, RST_GREEN_HIGH, RST_ABOVE_WHITE, RST_SIDE_MARGIN);
		tx_idle_on = 1'b0;
		hold_req <= hold_req + 1;
		for (int i = 0; i < 40; i++)
			send_sample(shaped_sample());
		tx_idle_on = 1'b1;
	endtask

	task automatic test_drain_pause();
		test_random_mix(20);
		wait_drained();
		test_random_mix(20);
	endtask

	// check each result, then choose the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (pending_classes.size() == 0) begin
					$display("%0t ERROR result expected none actual %h", $time, result);
					bad_fields++;
				end else begin
					want = pending_classes.pop_front();
					report_field("black_count", want.black_count, result.black_count);
					report_field("line_visible", want.line_visible, result.line_visible);
					report_field("crossing", want.crossing, result.crossing);
					report_field("split", want.split, result.split);
					report_field("green_line", want.green_line, result.green_line);
					report_field("grey_left", want.grey_left, result.grey_left);
					report_field("grey_right", want.grey_right, result.grey_right);
					report_field("grey_both", want.grey_both, result.grey_both);
				end
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (run_left > 0) begin
				run_left--;
			end else if (!rx_idle_on) begin
				result_stall <= 1'b0;
			end else if ($urandom_range(0, 2) == 0) begin
				run_left = idle_gap();
				result_stall <= 1'b1;
			end else begin
				run_left = $urandom_range(0, 12);
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
				|| (psel && penable && pready))
				quiet_count = 0;
			else
				quiet_count++;
			if (quiet_count >= WATCHDOG_LIMIT) begin
				$display("%0t ERROR watchdog expired", $time);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_defaults();
		test_random_defaults();
		test_reg_extremes();
		test_calibrated_grey();
		test_random_settings();
		test_backpressure();
		test_drain_pause();
		wait_drained();
		if (bad_fields == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
